// ===== rtl/core/dnsw_pkg.sv =====
// Shared types and constants of the DNS name text-to-wire converter.
package dnsw_pkg;

  localparam logic [7:0] CHR_NUL       = 8'h00;
  localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHR_DOT       = 8'h2E;
  localparam logic [7:0] CHR_ZERO      = 8'h30;
  localparam logic [7:0] CHR_NINE      = 8'h39;
  localparam logic [8:0] BUFFER_LIMIT  = 9'd255;
  localparam logic [1:0] ESCAPE_DIGITS_MAX = 2'd3;
  localparam int         DECIMAL_BASE  = 10;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_LENGTH = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // Largest number of results that one character can cause.
  localparam int RES_MAX = 3;

  typedef struct packed {
    logic [8:0] name_length;
    logic [6:0] label_count;
    logic [6:0] label_index;
    logic [7:0] value;
    logic [7:0] address;
    logic [1:0] kind;
  } result_t;

  // All results of one character, entry 0 first.
  typedef struct packed {
    logic [1:0]                 count;
    result_t [RES_MAX-1:0]      res;
  } bundle_t;

endpackage

// ===== rtl/core/dns_name_ascii_to_wire.sv =====
// Top level of the DNS domain name text-to-wire-format converter.
//
// Usage: characters of a domain name arrive on the s_axis channel, one per
// transfer, with a zero character ending each name. Each character is parsed
// in the cycle it is accepted; any of the zero to three results it causes
// (buffer writes of label bytes, label length writes, a done record, or an
// error) are queued as one bundle. The m_axis channel sends those results one
// per transfer, in order, with tlast on the final result of each character.
// The cfg channel writes max_label_length and is always ready; write it only
// while the block is idle.
// A character's bundle is registered in the queue, from which its results are
// offered on m_axis. Throughput: one character per cycle while each character
// causes at most one result and the receiver is ready; a character with
// several results occupies the output for one transfer per result, and the
// QUEUE_DEPTH-entry bundle queue absorbs such bursts so input keeps flowing.
// Reset (rst, synchronous) empties the queue, restarts the parser at the
// start of a name and sets max_label_length to 63. When the receiver stalls,
// the queue fills and s_axis_tready drops until a bundle is fully sent.
module dns_name_ascii_to_wire import dnsw_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write: max_label_length in bits 5:0.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,
  // Input stream. tdata: character [7:0].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  // Output stream. tdata: address [7:0], value [15:8], label_index [22:16],
  // label_count [29:23], name_length [38:30], zero [39]. tuser: kind [1:0].
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  logic [5:0] max_label_length;
  logic       accept;
  logic       push;
  logic       pop;
  logic       full;
  logic       empty;
  bundle_t    new_bundle;
  bundle_t    head;
  result_t    result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_label_length <= 6'd63;
    end else if (cfg_valid && cfg_ready) begin
      max_label_length <= cfg_data;
    end
  end

  // A character is taken whenever the queue has room for its bundle.
  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  dnsw_front u_front (
    .clk              (clk),
    .rst              (rst),
    .max_label_length (max_label_length),
    .character        (s_axis_tdata),
    .accept           (accept),
    .bundle           (new_bundle),
    .push             (push)
  );

  dnsw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (new_bundle),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  dnsw_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (empty),
    .ready  (m_axis_tready),
    .valid  (m_axis_tvalid),
    .result (result),
    .last   (m_axis_tlast),
    .pop    (pop)
  );

  assign m_axis_tuser = result.kind;
  assign m_axis_tdata = {1'b0, result.name_length, result.label_count,
                         result.label_index, result.value, result.address};

endmodule

// ===== rtl/core/dnsw_front.sv =====
// Front end: accepts characters, runs the name parser and builds result bundles.
module dnsw_front import dnsw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [5:0] max_label_length,
  input  logic [7:0] character,
  input  logic       accept,
  output bundle_t    bundle,
  output logic       push
);

  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_LABEL  = 3'd1;
  localparam logic [2:0] PH_ESCAPE = 3'd2;
  localparam logic [2:0] PH_DIGITS = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;

  logic [2:0] phase, phase_next;
  logic [8:0] write_offset, write_offset_next;
  logic [7:0] label_start_offset, label_start_offset_next;
  logic [6:0] current_label_length, current_label_length_next;
  logic [6:0] labels_done, labels_done_next;
  logic [9:0] escape_value, escape_value_next;
  logic [1:0] escape_digit_count, escape_digit_count_next;

  logic       is_digit;
  logic [3:0] digit;
  logic [13:0] escape_product;
  logic       do_label_char;
  logic       do_name;
  logic       do_restart;
  logic [1:0] n;

  function automatic result_t mk(input logic [1:0] kind, input logic [7:0] address,
                                 input logic [7:0] value, input logic [6:0] idx,
                                 input logic [6:0] cnt, input logic [8:0] len);
    result_t r;
    r.kind        = kind;
    r.address     = address;
    r.value       = value;
    r.label_index = idx;
    r.label_count = cnt;
    r.name_length = len;
    return r;
  endfunction

  assign is_digit = (character >= CHR_ZERO) && (character <= CHR_NINE);
  assign digit    = 4'(character - CHR_ZERO);
  assign escape_product = {4'b0, escape_value} * 14'(DECIMAL_BASE) + {10'b0, digit};

  always_comb begin
    phase_next                = phase;
    write_offset_next         = write_offset;
    label_start_offset_next   = label_start_offset;
    current_label_length_next = current_label_length;
    labels_done_next          = labels_done;
    escape_value_next         = escape_value;
    escape_digit_count_next   = escape_digit_count;
    do_label_char             = 1'b0;
    do_name                   = 1'b0;
    do_restart                = 1'b0;
    n                         = 2'd0;
    bundle.res                = '0;

    case (phase)
      PH_START: begin
        if (character == CHR_NUL) begin
          do_name = 1'b1;
        end else if (character != CHR_DOT) begin
          phase_next                = PH_LABEL;
          current_label_length_next = 7'd0;
          do_label_char             = 1'b1;
        end
      end
      PH_LABEL: begin
        do_label_char = 1'b1;
      end
      PH_ESCAPE: begin
        if (character == CHR_NUL) begin
          bundle.res[n] = mk(KIND_ERROR, 8'd0, 8'd0, 7'd0, 7'd0, 9'd0);
          n = n + 2'd1;
          do_restart = 1'b1;
        end else if (is_digit) begin
          escape_value_next       = {6'b0, digit};
          escape_digit_count_next = 2'd1;
          phase_next              = PH_DIGITS;
        end else begin
          bundle.res[n] = mk(KIND_DATA, write_offset_next[7:0], character,
                             7'd0, 7'd0, 9'd0);
          n = n + 2'd1;
          write_offset_next = write_offset_next + 9'd1;
          phase_next        = PH_LABEL;
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          escape_value_next       = escape_product[9:0];
          escape_digit_count_next = escape_digit_count + 2'd1;
          if (escape_digit_count_next >= ESCAPE_DIGITS_MAX) begin
            bundle.res[n] = mk(KIND_DATA, write_offset_next[7:0],
                               escape_value_next[7:0], 7'd0, 7'd0, 9'd0);
            n = n + 2'd1;
            write_offset_next       = write_offset_next + 9'd1;
            escape_value_next       = 10'd0;
            escape_digit_count_next = 2'd0;
            phase_next              = PH_LABEL;
          end
        end else begin
          bundle.res[n] = mk(KIND_DATA, write_offset_next[7:0], escape_value[7:0],
                             7'd0, 7'd0, 9'd0);
          n = n + 2'd1;
          write_offset_next       = write_offset_next + 9'd1;
          escape_value_next       = 10'd0;
          escape_digit_count_next = 2'd0;
          phase_next              = PH_LABEL;
          do_label_char           = 1'b1;
        end
      end
      default: begin
        // Rest of a rejected name: wait for its terminating zero.
        if (character == CHR_NUL) begin
          do_restart = 1'b1;
        end else begin
          phase_next = PH_SKIP;
        end
      end
    endcase

    if (do_label_char) begin
      if ((character == CHR_NUL) || (character == CHR_DOT)) begin
        bundle.res[n] = mk(KIND_LENGTH, label_start_offset_next,
                           {1'b0, current_label_length_next}, labels_done_next,
                           7'd0, 9'd0);
        n = n + 2'd1;
        labels_done_next          = labels_done_next + 7'd1;
        label_start_offset_next   = write_offset_next[7:0];
        write_offset_next         = {1'b0, label_start_offset_next} + 9'd1;
        current_label_length_next = 7'd0;
        if (character == CHR_NUL) begin
          do_name = 1'b1;
        end else begin
          phase_next = PH_START;
        end
      end else if ((current_label_length_next >= {1'b0, max_label_length}) ||
                   (write_offset_next >= BUFFER_LIMIT)) begin
        bundle.res[n] = mk(KIND_ERROR, 8'd0, 8'd0, 7'd0, 7'd0, 9'd0);
        n = n + 2'd1;
        phase_next = PH_SKIP;
      end else begin
        current_label_length_next = current_label_length_next + 7'd1;
        if (character == CHR_BACKSLASH) begin
          phase_next = PH_ESCAPE;
        end else begin
          bundle.res[n] = mk(KIND_DATA, write_offset_next[7:0], character,
                             7'd0, 7'd0, 9'd0);
          n = n + 2'd1;
          write_offset_next = write_offset_next + 9'd1;
        end
      end
    end

    if (do_name) begin
      bundle.res[n] = mk(KIND_DONE, label_start_offset_next, 8'd0, 7'd0,
                         labels_done_next, {1'b0, label_start_offset_next} + 9'd1);
      n = n + 2'd1;
      do_restart = 1'b1;
    end

    if (do_restart) begin
      phase_next                = PH_START;
      write_offset_next         = 9'd1;
      label_start_offset_next   = 8'd0;
      current_label_length_next = 7'd0;
      labels_done_next          = 7'd0;
      escape_value_next         = 10'd0;
      escape_digit_count_next   = 2'd0;
    end

    bundle.count = n;
  end

  assign push = accept && (n != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                <= PH_START;
      write_offset         <= 9'd1;
      label_start_offset   <= 8'd0;
      current_label_length <= 7'd0;
      labels_done          <= 7'd0;
      escape_value         <= 10'd0;
      escape_digit_count   <= 2'd0;
    end else if (accept) begin
      phase                <= phase_next;
      write_offset         <= write_offset_next;
      label_start_offset   <= label_start_offset_next;
      current_label_length <= current_label_length_next;
      labels_done          <= labels_done_next;
      escape_value         <= escape_value_next;
      escape_digit_count   <= escape_digit_count_next;
    end
  end

endmodule

// ===== rtl/core/dnsw_queue.sv =====
// Small FIFO of result bundles between the parser and the output serializer.
module dnsw_queue import dnsw_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output bundle_t head,
  output logic    full,
  output logic    empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  bundle_t        mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  fill;
  logic           do_push;
  logic           do_pop;

  assign full    = (fill == CW'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/dnsw_back.sv =====
// Back end: sends the results of each queued bundle one transfer at a time.
module dnsw_back import dnsw_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  bundle_t head,
  input  logic    empty,
  input  logic    ready,
  output logic    valid,
  output result_t result,
  output logic    last,
  output logic    pop
);

  logic [1:0] sel;

  assign valid  = !empty;
  assign result = head.res[sel];
  assign last   = (sel == head.count - 2'd1);
  assign pop    = valid && ready && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 2'd0;
    end else if (valid && ready) begin
      sel <= last ? 2'd0 : sel + 2'd1;
    end
  end

endmodule
